@@ design/costmap_gradient_escape_step_core_macros.svh @@
// Assertion macros shared by the escape-step RTL.
// CGE_ASSERT checks a property outside reset, CGE_ASSERT_NR checks it at every edge.
`ifndef COSTMAP_GRADIENT_ESCAPE_STEP_CORE_MACROS_SVH
`define COSTMAP_GRADIENT_ESCAPE_STEP_CORE_MACROS_SVH

`ifndef ASSERT_OFF
`define CGE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CGE_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CGE_ASSERT(lbl, clk, rst_n, prop, msg)
`define CGE_ASSERT_NR(lbl, clk, prop, msg)
`endif

`endif

@@ design/cge_pkg.sv @@
`default_nettype none

package cge_pkg;

    // cost and gradient widths
    localparam int COST_BITS = 8;
    localparam int GRAD_BITS = COST_BITS + 1;
    localparam int WIN_BITS  = 6;

    // CORDIC datapath
    localparam int CORDIC_STEPS = 28;
    localparam int STEP_BITS    = 5;
    localparam int CORDIC_SCALE = 24;
    localparam int CORDIC_W     = 36;
    localparam int ACC_BITS     = 32;

    // configuration port
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 15;

    localparam logic [CFG_IDX_BITS-1:0] REG_ESCAPE_LEVEL      = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_LETHAL_LEVEL      = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_MIN_WINDOW        = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_MAX_WINDOW        = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_TURN_SPEED        = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_HEADING_TOLERANCE = 3'd5;

    // register reset values
    localparam logic [7:0]  RST_ESCAPE_LEVEL      = 8'd100;
    localparam logic [7:0]  RST_LETHAL_LEVEL      = 8'd253;
    localparam logic [5:0]  RST_MIN_WINDOW        = 6'd2;
    localparam logic [5:0]  RST_MAX_WINDOW        = 6'd10;
    localparam logic [11:0] RST_TURN_SPEED        = 12'd400;
    localparam logic [14:0] RST_HEADING_TOLERANCE = 15'd1043;

    // result status codes
    localparam logic [1:0] ST_COMMAND   = 2'd0;
    localparam logic [1:0] ST_ESCAPED   = 2'd1;
    localparam logic [1:0] ST_ABORT_MAX = 2'd2;
    localparam logic [1:0] ST_ABORT_MIN = 2'd3;

    // request to the arctangent unit
    typedef struct packed {
        logic                        start;
        logic signed [GRAD_BITS-1:0] ex;
        logic signed [GRAD_BITS-1:0] ey;
    } cge_cordic_req_t;

    // arctangent unit status
    typedef struct packed {
        logic busy;
        logic done;
    } cge_cordic_stat_t;

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic [ACC_BITS-1:0] cge_atan(input logic [STEP_BITS-1:0] i);
        logic [ACC_BITS-1:0] a;
        case (i)
            5'd0:  a = 32'd536870912;
            5'd1:  a = 32'd316933406;
            5'd2:  a = 32'd167458907;
            5'd3:  a = 32'd85004756;
            5'd4:  a = 32'd42667331;
            5'd5:  a = 32'd21354465;
            5'd6:  a = 32'd10679838;
            5'd7:  a = 32'd5340245;
            5'd8:  a = 32'd2670163;
            5'd9:  a = 32'd1335087;
            5'd10: a = 32'd667544;
            5'd11: a = 32'd333772;
            5'd12: a = 32'd166886;
            5'd13: a = 32'd83443;
            5'd14: a = 32'd41722;
            5'd15: a = 32'd20861;
            5'd16: a = 32'd10430;
            5'd17: a = 32'd5215;
            5'd18: a = 32'd2608;
            5'd19: a = 32'd1304;
            5'd20: a = 32'd652;
            5'd21: a = 32'd326;
            5'd22: a = 32'd163;
            5'd23: a = 32'd81;
            5'd24: a = 32'd41;
            5'd25: a = 32'd20;
            5'd26: a = 32'd10;
            5'd27: a = 32'd5;
            default: a = 32'd0;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

@@ design/cge_cordic.sv @@
`default_nettype none
`include "costmap_gradient_escape_step_core_macros.svh"

// Vectoring CORDIC: one micro-rotation per cycle, heading rounded to ANGLE_BITS.
module cge_cordic #(
    parameter int ANGLE_BITS = 16
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire cge_pkg::cge_cordic_req_t    req,
    output cge_pkg::cge_cordic_stat_t        stat,
    output logic [ANGLE_BITS-1:0]            heading
);
    import cge_pkg::*;

    localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(CORDIC_STEPS - 1);
    localparam logic [ACC_BITS-1:0]  ROUND_ONE = ACC_BITS'(1) << (ACC_BITS - 1 - ANGLE_BITS);
    localparam logic [ACC_BITS-1:0]  HALF_TURN = ACC_BITS'(1) << (ACC_BITS - 1);

    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [STEP_BITS-1:0]       step_reg, step_next;
    logic signed [CORDIC_W-1:0] x_reg, x_next;
    logic signed [CORDIC_W-1:0] y_reg, y_next;
    logic [ACC_BITS-1:0]        acc_reg, acc_next;
    logic [ANGLE_BITS-1:0]      heading_reg, heading_next;

    logic signed [CORDIC_W-1:0] ex_s, ey_s, sx, sy;
    logic [ACC_BITS-1:0]        atan_i, acc_rnd;
    logic                       y_pos;

    // operand scaling and shifted terms
    assign ex_s   = CORDIC_W'(req.ex) <<< CORDIC_SCALE;
    assign ey_s   = CORDIC_W'(req.ey) <<< CORDIC_SCALE;
    assign sx     = x_reg >>> step_reg;
    assign sy     = y_reg >>> step_reg;
    assign y_pos  = !y_reg[CORDIC_W-1] && (y_reg != '0);
    assign atan_i = cge_atan(step_reg);
    // accumulator after this step, rounded for the last one
    assign acc_rnd = (y_pos ? (acc_reg + atan_i) : (acc_reg - atan_i)) + ROUND_ONE;

    // sequencer and micro-rotation
    always_comb begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        step_next    = step_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        acc_next     = acc_reg;
        heading_next = heading_reg;
        if (!busy_reg) begin
            if (req.start) begin
                if (req.ex == '0 && req.ey == '0) begin
                    // atan2(0,0) is defined as zero
                    heading_next = '0;
                    done_next    = 1'b1;
                end else begin
                    busy_next = 1'b1;
                    step_next = '0;
                    if (req.ex < 0) begin
                        x_next   = -ex_s;
                        y_next   = -ey_s;
                        acc_next = HALF_TURN;
                    end else begin
                        x_next   = ex_s;
                        y_next   = ey_s;
                        acc_next = '0;
                    end
                end
            end
        end else begin
            if (y_pos) begin
                x_next   = x_reg + sy;
                y_next   = y_reg - sx;
                acc_next = acc_reg + atan_i;
            end else begin
                x_next   = x_reg - sy;
                y_next   = y_reg + sx;
                acc_next = acc_reg - atan_i;
            end
            if (step_reg == LAST_STEP) begin
                busy_next    = 1'b0;
                done_next    = 1'b1;
                heading_next = acc_rnd[ACC_BITS-1 -: ANGLE_BITS];
            end else begin
                step_next = step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        x_reg       <= x_next;
        y_reg       <= y_next;
        acc_reg     <= acc_next;
        heading_reg <= heading_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign heading   = heading_reg;

    `CGE_ASSERT(a_step_range, aclk, aresetn, busy_reg |-> (step_reg <= LAST_STEP), "cordic step out of range")
    `CGE_ASSERT(a_done_pulse, aclk, aresetn, done_reg |=> !done_reg, "cordic done longer than one cycle")
    `CGE_ASSERT(a_x_nonneg, aclk, aresetn, busy_reg |-> !x_reg[CORDIC_W-1], "cordic x went negative")

endmodule

`default_nettype wire

@@ design/costmap_gradient_escape_step_core.sv @@
`default_nettype none
`include "costmap_gradient_escape_step_core_macros.svh"

// Channel   Dir  Fields (lowest bit first)
// s_axis    in   tdata: centre_cost[7:0] cost_west[15:8] cost_east[23:16] cost_south[31:24]
//                cost_north[39:32] yaw_now[55:40]
// m_axis    out  tuser: status[1:0]
//                tdata: escape_heading[15:0] angular_speed[28:16] creep_forward[29]
//                next_window[35:30]
// cfg       in   cfg_wr_en / cfg_index / cfg_wr_data, write only
//
// From the input transfer to m_tvalid a command result passes the decide state,
// 28 steps of the CORDIC micro-rotation unit and the finish state.
// Escaped and abort results skip the CORDIC; a flat command tick passes decide, run, finish.
// One item at a time: s_tready is high only while the sequencer is idle, so a new
// item waits until the last leaves the finish state, which a stalled m_tready holds.
// aresetn is synchronous, active low; registers return to defaults, window to 2.
// A result waits in the output register; the next item is taken meanwhile.
module costmap_gradient_escape_step_core #(
    parameter int ANGLE_BITS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // centre, west, east, south, north, yaw_now
    input  wire logic [55:0] s_tdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // escape_heading, angular_speed, creep_forward, next_window, 4 pad bits
    output logic [39:0]      m_tdata,
    // status
    output logic [1:0]       m_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    input  wire logic                               cfg_wr_en,
    input  wire logic [cge_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  wire logic [cge_pkg::CFG_DATA_BITS-1:0]  cfg_wr_data
);
    import cge_pkg::*;

    localparam int MAG_W = (ANGLE_BITS > 15) ? ANGLE_BITS : 15;
    localparam int HDG_W = (ANGLE_BITS > 16) ? ANGLE_BITS : 16;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_DECIDE = 2'd1;
    localparam logic [1:0] S_RUN    = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0] state_reg, state_next;

    // configuration registers
    logic [7:0]  escape_level_reg, lethal_level_reg;
    logic [5:0]  min_window_reg, max_window_reg;
    logic [11:0] turn_speed_reg;
    logic [14:0] heading_tolerance_reg;

    logic [WIN_BITS-1:0] window_reg, window_next;
    logic [1:0]          status_reg, status_next;

    // captured input item
    logic [COST_BITS-1:0] centre_reg, west_reg, east_reg, south_reg, north_reg;
    logic [15:0]          yaw_reg;

    // output register
    logic        m_tvalid_reg;
    logic [1:0]  out_status_reg;
    logic [15:0] out_heading_reg;
    logic [12:0] out_speed_reg;
    logic        out_creep_reg;
    logic [5:0]  out_window_reg;

    cge_cordic_req_t  creq;
    cge_cordic_stat_t cstat;
    logic [ANGLE_BITS-1:0] cheading;

    logic                s_xfer, out_free, load_out;
    logic                escaped, flat, lethal, over;
    logic [WIN_BITS:0]   win_inc;
    logic [WIN_BITS-1:0] start_win;

    logic [ANGLE_BITS-1:0] yaw_ext, err, mag;
    logic [MAG_W-1:0]      mag_ext, tol_ext;
    logic signed [HDG_W-1:0] hdg_ext;
    logic        creep_c;
    logic [12:0] speed_c;

    assign s_tready = (state_reg == S_IDLE);
    assign s_xfer   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign load_out = (state_reg == S_FINISH) && out_free;

    // tick classification
    assign escaped   = (centre_reg <= escape_level_reg);
    assign flat      = (east_reg == west_reg) && (north_reg == south_reg);
    assign lethal    = (centre_reg >= lethal_level_reg);
    assign win_inc   = {1'b0, window_reg} + 1'b1;
    assign over      = (win_inc > {1'b0, max_window_reg});
    assign start_win = (min_window_reg == '0) ? WIN_BITS'(1) : min_window_reg;

    always_comb begin
        if (escaped) begin
            status_next = ST_ESCAPED;
        end else if (flat && lethal && over) begin
            status_next = ST_ABORT_MAX;
        end else if (flat && !lethal) begin
            status_next = ST_ABORT_MIN;
        end else begin
            status_next = ST_COMMAND;
        end
    end

    always_comb begin
        window_next = window_reg;
        if (state_reg == S_DECIDE) begin
            if (status_next == ST_COMMAND && flat) begin
                window_next = win_inc[WIN_BITS-1:0];
            end else begin
                window_next = start_win;
            end
        end
    end

    // heading request: atan2 of the negated gradient
    assign creq.start = (state_reg == S_DECIDE) && (status_next == ST_COMMAND);
    assign creq.ex    = $signed({1'b0, west_reg}) - $signed({1'b0, east_reg});
    assign creq.ey    = $signed({1'b0, south_reg}) - $signed({1'b0, north_reg});

    cge_cordic #(
        .ANGLE_BITS(ANGLE_BITS)
    ) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (creq),
        .stat    (cstat),
        .heading (cheading)
    );

    // heading error and turn command
    assign yaw_ext = ANGLE_BITS'(yaw_reg);
    assign err     = cheading - yaw_ext;
    assign mag     = err[ANGLE_BITS-1] ? (~err + 1'b1) : err;
    assign mag_ext = MAG_W'(mag);
    assign tol_ext = MAG_W'(heading_tolerance_reg);
    assign creep_c = (mag_ext < tol_ext);
    assign hdg_ext = HDG_W'($signed(cheading));

    always_comb begin
        if (creep_c || err == '0) begin
            speed_c = '0;
        end else if (err[ANGLE_BITS-1]) begin
            speed_c = 13'd0 - {1'b0, turn_speed_reg};
        end else begin
            speed_c = {1'b0, turn_speed_reg};
        end
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_xfer) begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                state_next = (status_next == ST_COMMAND) ? S_RUN : S_FINISH;
            end
            S_RUN: begin
                if (cstat.done) begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg             <= S_IDLE;
            window_reg            <= RST_MIN_WINDOW;
            escape_level_reg      <= RST_ESCAPE_LEVEL;
            lethal_level_reg      <= RST_LETHAL_LEVEL;
            min_window_reg        <= RST_MIN_WINDOW;
            max_window_reg        <= RST_MAX_WINDOW;
            turn_speed_reg        <= RST_TURN_SPEED;
            heading_tolerance_reg <= RST_HEADING_TOLERANCE;
            m_tvalid_reg          <= 1'b0;
        end else begin
            state_reg  <= state_next;
            window_reg <= window_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_ESCAPE_LEVEL:      escape_level_reg      <= cfg_wr_data[7:0];
                    REG_LETHAL_LEVEL:      lethal_level_reg      <= cfg_wr_data[7:0];
                    REG_MIN_WINDOW:        min_window_reg        <= cfg_wr_data[5:0];
                    REG_MAX_WINDOW:        max_window_reg        <= cfg_wr_data[5:0];
                    REG_TURN_SPEED:        turn_speed_reg        <= cfg_wr_data[11:0];
                    REG_HEADING_TOLERANCE: heading_tolerance_reg <= cfg_wr_data[14:0];
                    default: ;
                endcase
            end
            if (load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload capture
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            centre_reg <= s_tdata[7:0];
            west_reg   <= s_tdata[15:8];
            east_reg   <= s_tdata[23:16];
            south_reg  <= s_tdata[31:24];
            north_reg  <= s_tdata[39:32];
            yaw_reg    <= s_tdata[55:40];
        end
        if (state_reg == S_DECIDE) begin
            status_reg <= status_next;
        end
        if (load_out) begin
            out_status_reg <= status_reg;
            out_window_reg <= window_reg;
            if (status_reg == ST_COMMAND) begin
                out_heading_reg <= hdg_ext[15:0];
                out_speed_reg   <= speed_c;
                out_creep_reg   <= creep_c;
            end else begin
                out_heading_reg <= '0;
                out_speed_reg   <= '0;
                out_creep_reg   <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {4'b0000, out_window_reg, out_creep_reg, out_speed_reg,
                       out_heading_reg};

    `CGE_ASSERT(a_run_has_cordic, aclk, aresetn, (state_reg == S_RUN) |-> (cstat.busy || cstat.done), "sequencer waits on an idle cordic")
    `CGE_ASSERT(a_end_fields_zero, aclk, aresetn, (m_tvalid_reg && (out_status_reg != ST_COMMAND)) |-> ((out_heading_reg == '0) && (out_speed_reg == '0) && !out_creep_reg), "ended tick carries a command")
    `CGE_ASSERT(a_creep_no_turn, aclk, aresetn, (m_tvalid_reg && out_creep_reg) |-> (out_speed_reg == '0), "creep with nonzero turn")
    `CGE_ASSERT(a_window_nonzero, aclk, aresetn, window_reg != '0, "window size is zero")
    `CGE_ASSERT_NR(a_reset_clears_out, aclk, !aresetn |=> !m_tvalid_reg, "result valid after reset")

endmodule

`default_nettype wire
